### rtl/core/cslf_pkg.sv
// ----------------------------------------------------------------------------
// cslf_pkg
// Shared constants, codes and sequencer states for the cache set unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cslf_pkg;

  // default geometry
  localparam int DEF_WAYS     = 4;
  localparam int DEF_TAG_BITS = 32;

  // fixed width of the tag fields on the channels
  localparam int TAG_W = 32;

  // replacement policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // access kind codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  // policy value after reset
  localparam logic POLICY_RESET = POLICY_LRU;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

### rtl/core/cslf_req_if.sv
// ----------------------------------------------------------------------------
// cslf_req_if
// Access request channel: tag and access kind with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cslf_req_if
  import cslf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] tag;
  logic             func;

  modport source (output valid, output tag, output func, input ready);
  modport sink   (input valid, input tag, input func, output ready);
endinterface

`default_nettype wire

### rtl/core/cslf_rsp_if.sv
// ----------------------------------------------------------------------------
// cslf_rsp_if
// Access result channel: hit flag and dirty eviction report with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cslf_rsp_if
  import cslf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             victim_dirty;
  logic [TAG_W-1:0] evicted_tag;

  modport source (output valid, output hit, output victim_dirty, output evicted_tag,
                  input ready);
  modport sink   (input valid, input hit, input victim_dirty, input evicted_tag,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/cache_set_lru_fifo_unit.sv
// ----------------------------------------------------------------------------
// cache_set_lru_fifo_unit
// One write-back cache set with FIFO or LRU replacement. A single tag
// comparator walks the ways one per cycle, then an update step writes the set.
// ----------------------------------------------------------------------------
// Sequence: accept in idle, then a scan of up to WAYS ways (one tag compare
//   per way, stopping at the hit way), then an update step that waits while
//   the result register holds an untaken result and loads it when done.
// One transaction at a time: a new request is taken only back in idle,
//   since the single tag comparator is shared by all ways.
// Reset (rst, synchronous): policy = LRU, set cleared, sequencer idle.
// A policy write clears the set in the same cycle.
`default_nettype none

module cache_set_lru_fifo_unit
  import cslf_pkg::*;
#(
  parameter int WAYS     = DEF_WAYS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  cslf_req_if.sink    req,
  cslf_rsp_if.source  rsp
);

  // way index, queue count and stored tag widths
  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);
  localparam int SW = ((IW > CW) ? IW : CW) + 1;
  localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam logic [IW-1:0] LAST_WAY = IW'(WAYS - 1);

  // set state
  logic          policy;
  logic          way_valid  [WAYS];
  logic [TW-1:0] way_tag    [WAYS];
  logic          way_dirty  [WAYS];
  logic [IW-1:0] way_age    [WAYS];
  logic [IW-1:0] fill_order [WAYS];
  logic [IW-1:0] order_head;
  logic [CW-1:0] order_count;

  // sequencer and per-transaction registers
  state_t        state, state_next;
  logic [IW-1:0] idx;
  logic [TW-1:0] tag_q;
  logic          func_q;
  logic          found;
  logic [IW-1:0] hit_way;
  logic [IW-1:0] hit_age;
  logic          have_empty;
  logic [IW-1:0] empty_way;
  logic          have_old;
  logic [IW-1:0] max_age;
  logic [IW-1:0] old_way;
  logic [TW-1:0] old_tag;
  logic          old_dirty;
  logic [TW-1:0] fv_tag;
  logic          fv_dirty;
  logic          out_valid;

  // control outputs of the sequencer
  logic scan_en, upd_en, accept, out_free, match;

  // fifo victim, chosen update way, eviction and queue arithmetic
  logic [IW-1:0] fv_way;
  logic [IW-1:0] upd;
  logic          evict;
  logic          ev_dirty;
  logic [TW-1:0] ev_tag;
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] tail;
  logic [IW-1:0] head_inc;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign match    = way_valid[idx] && (way_tag[idx] == tag_q);
  assign fv_way   = (order_count != '0) ? fill_order[order_head] : '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid) state_next = ST_SCAN;
      ST_SCAN:   if (match || idx == LAST_WAY) state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    scan_en   = 1'b0;
    upd_en    = 1'b0;
    case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_SCAN:   scan_en   = 1'b1;
      ST_UPDATE: upd_en    = out_free;
      default:   req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // victim selection and queue positions
  always_comb begin
    evict = !found && !have_empty;
    if (found)                     upd = hit_way;
    else if (have_empty)           upd = empty_way;
    else if (policy == POLICY_FIFO) upd = fv_way;
    else                           upd = old_way;
    ev_dirty = evict && ((policy == POLICY_FIFO) ? fv_dirty : old_dirty);
    ev_tag   = (policy == POLICY_FIFO) ? fv_tag : old_tag;
    tail_sum = SW'(order_head) + SW'(order_count);
    if (tail_sum >= SW'(WAYS)) tail = IW'(tail_sum - SW'(WAYS));
    else                       tail = IW'(tail_sum);
    head_inc = (order_head == LAST_WAY) ? '0 : IW'(order_head + 1'b1);
  end

  // request capture and way scan, one way per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q      <= req.tag[TW-1:0];
      func_q     <= req.func;
      idx        <= '0;
      found      <= 1'b0;
      have_empty <= 1'b0;
      have_old   <= 1'b0;
      fv_dirty   <= 1'b0;
      fv_tag     <= '0;
    end else if (scan_en) begin
      if (idx == fv_way) begin
        fv_tag   <= way_tag[idx];
        fv_dirty <= way_dirty[idx];
      end
      if (match) begin
        found   <= 1'b1;
        hit_way <= idx;
        hit_age <= way_age[idx];
      end else if (way_valid[idx]) begin
        if (!have_old || way_age[idx] >= max_age) begin
          have_old  <= 1'b1;
          max_age   <= way_age[idx];
          old_way   <= idx;
          old_tag   <= way_tag[idx];
          old_dirty <= way_dirty[idx];
        end
      end else if (!have_empty) begin
        have_empty <= 1'b1;
        empty_way  <= idx;
      end
      if (idx != LAST_WAY) idx <= IW'(idx + 1'b1);
    end
  end

  // set state: clear on reset or policy write, update after the scan
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      policy      <= rst ? POLICY_RESET : cfg_wdata;
      order_head  <= '0;
      order_count <= '0;
      for (int w = 0; w < WAYS; w++) begin
        way_valid[w] <= 1'b0;
        way_dirty[w] <= 1'b0;
        way_age[w]   <= '0;
      end
    end else if (upd_en) begin
      if (!found) begin
        way_valid[upd] <= 1'b1;
        way_tag[upd]   <= tag_q;
      end
      if (func_q == FUNC_STORE) way_dirty[upd] <= 1'b1;
      else if (!found)          way_dirty[upd] <= 1'b0;
      // fifo bookkeeping
      if (policy == POLICY_FIFO) begin
        if (!found && have_empty && order_count < CW'(WAYS)) begin
          fill_order[tail] <= upd;
          order_count      <= CW'(order_count + 1'b1);
        end
        if (evict && order_count != '0) order_head <= head_inc;
      end
      // lru ages younger ways (all on a miss) by one; updated way is newest
      if (policy == POLICY_LRU) begin
        for (int w = 0; w < WAYS; w++) begin
          if (IW'(w) == upd)
            way_age[w] <= '0;
          else if (way_valid[w] && (!found || way_age[w] < hit_age))
            way_age[w] <= IW'(way_age[w] + 1'b1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_en) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      rsp.hit          <= found;
      rsp.victim_dirty <= ev_dirty;
      rsp.evicted_tag  <= ev_dirty ? TAG_W'(ev_tag) : '0;
    end
  end

  assign rsp.valid = out_valid;

  // checks
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("accepted transaction did not start a scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    order_count <= CW'(WAYS))
    else $error("fill queue count exceeds way count");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && found) |-> way_valid[hit_way])
    else $error("hit recorded on an invalid way");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_UPDATE)
    else $error("result raised outside the update step");

endmodule

`default_nettype wire
